/* hdl/assert_macros.svh */
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with async reset disable
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// never-true check
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`endif

/* hdl/lc3_pkg.sv */
// package for the lc3 execute unit: types, constants, helpers
`timescale 1ns / 1ps
package lc3_pkg;
  localparam int unsigned AddrBits = 16;
  localparam int unsigned WordBits = 16;

  typedef enum logic [1:0] {
    REQ_MEM_WRITE = 2'd0,
    REQ_SET_PC    = 2'd1,
    REQ_EXECUTE   = 2'd2,
    REQ_NONE      = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'h0, OP_ADD  = 4'h1, OP_LD   = 4'h2, OP_ST   = 4'h3,
    OP_JSR  = 4'h4, OP_AND  = 4'h5, OP_LDR  = 4'h6, OP_STR  = 4'h7,
    OP_RTI  = 4'h8, OP_NOT  = 4'h9, OP_LDI  = 4'hA, OP_STI  = 4'hB,
    OP_JMP  = 4'hC, OP_RES  = 4'hD, OP_LEA  = 4'hE, OP_TRAP = 4'hF
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ1,
    ST_READ2,
    ST_FINISH,
    ST_OUT
  } ctrl_state_e;

  localparam logic [2:0] CcN = 3'd4;
  localparam logic [2:0] CcZ = 3'd2;
  localparam logic [2:0] CcP = 3'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [15:0] word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
    logic [2:0]  cond_codes;
    logic        unimplemented;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;  // capture input transaction
    logic rd1;        // issue first memory read
    logic rd2;        // issue second (indirect) read
    logic finish;     // commit state and build result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_rd1;
    logic needs_rd2;
  } dp_status_t;

  function automatic logic [15:0] sext(input logic [15:0] v, input int unsigned bits);
    logic [15:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (i >= bits) r[i] = v[bits-1];
    end
    return r;
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] r;
    if (v[15]) r = CcN;
    else if (v == 16'd0) r = CcZ;
    else r = CcP;
    return r;
  endfunction
endpackage

/* hdl/lc3_instruction_execute_unit.sv */
// lc3 execute unit: one request per transaction, one result per request
// sequence: take, read, finish, with a second read for ldi; the result is registered at finish
// a new transaction is taken only after the last one commits; commit waits while the output stalls
// reset: async active low clears pc, condition codes and the eight registers
// memory contents are not reset and are undefined until written
`timescale 1ns / 1ps
module lc3_instruction_execute_unit import lc3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: take, read memory, optional indirect read, commit
  lc3_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  // register file, pc, memory and result register
  lc3_dpath u_dpath (
    .clk_i, .rst_ni, .in_item_i(in_data_i), .cmd_i(cmd),
    .status_o(status), .out_item_o(out_data_o)
  );
endmodule

/* hdl/lc3_ctrl.sv */
// controller state machine for the lc3 execute unit
`timescale 1ns / 1ps
module lc3_ctrl import lc3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);
  ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_READ1;
        end
      end
      ST_READ1: begin
        cmd_o.rd1 = status_i.needs_rd1;
        state_d = status_i.needs_rd2 ? ST_READ2 : ST_FINISH;
      end
      ST_READ2: begin
        cmd_o.rd2 = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // result register must be free before commit
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
endmodule

/* hdl/lc3_dpath.sv */
// datapath of the lc3 execute unit: registers, memory, alu, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lc3_dpath import lc3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_item_o
);
  localparam int unsigned Depth = 1 << AddrBits;

  logic [15:0] mem_q [Depth];
  logic [15:0] rdata_q;
  logic [15:0] regs_q [8];
  logic [15:0] pc_q;
  logic [2:0]  cc_q;
  in_item_t    item_q;
  out_item_t   res_q, res_d;

  opcode_e     op;
  logic [2:0]  dr, sr1;
  logic [15:0] ir, pc1, pc_off9, rd_addr, ptr_q;
  logic        mem_we;
  logic [AddrBits-1:0] mem_wa, mem_ra;
  logic [15:0] mem_wd;

  assign ir      = item_q.word;
  assign op      = opcode_e'(ir[15:12]);
  assign dr      = ir[11:9];
  assign sr1     = ir[8:6];
  assign pc1     = pc_q + 16'd1;
  assign pc_off9 = pc1 + sext(ir, 9);

  assign status_o.needs_rd1 = (item_q.req_type == REQ_EXECUTE) &&
    (op == OP_LD || op == OP_LDI || op == OP_LDR || op == OP_STI || op == OP_TRAP);
  assign status_o.needs_rd2 = (item_q.req_type == REQ_EXECUTE) && (op == OP_LDI);

  // first read address by opcode
  always_comb begin
    case (op)
      OP_LDR:  rd_addr = regs_q[sr1] + sext(ir, 6);
      OP_TRAP: rd_addr = {8'd0, ir[7:0]};
      default: rd_addr = pc_off9;
    endcase
  end

  assign mem_ra = cmd_i.rd2 ? rdata_q[AddrBits-1:0] : rd_addr[AddrBits-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_item_i;
    if (cmd_i.rd1 || cmd_i.rd2) rdata_q <= mem_q[mem_ra];
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (cmd_i.finish) res_q <= res_d;
  end
  assign ptr_q = rdata_q;

  always_comb begin
    logic [15:0] b, pc_n;
    logic        rw, mw, un, setcc;
    logic [2:0]  ri;
    logic [15:0] rv, ma;
    b = ir[5] ? sext(ir, 5) : regs_q[ir[2:0]];
    pc_n = pc1; rw = 1'b0; mw = 1'b0; un = 1'b0; setcc = 1'b0;
    ri = 3'd0; rv = 16'd0; ma = 16'd0;
    case (op)
      OP_ADD: begin rv = regs_q[sr1] + b; rw = 1'b1; ri = dr; setcc = 1'b1; end
      OP_AND: begin rv = regs_q[sr1] & b; rw = 1'b1; ri = dr; setcc = 1'b1; end
      OP_NOT: begin rv = ~regs_q[sr1]; rw = 1'b1; ri = dr; setcc = 1'b1; end
      OP_BR:  if ((dr & cc_q) != 3'd0) pc_n = pc_off9;
      OP_JMP: pc_n = regs_q[sr1];
      OP_JSR: begin
        rv = pc1; rw = 1'b1; ri = 3'd7;
        pc_n = ir[11] ? pc1 + sext(ir, 11) : regs_q[sr1];
      end
      OP_LD, OP_LDI, OP_LDR: begin
        rv = ptr_q; rw = 1'b1; ri = dr; setcc = 1'b1;
      end
      OP_LEA: begin rv = pc_off9; rw = 1'b1; ri = dr; setcc = 1'b1; end
      OP_ST:  begin ma = pc_off9; mw = 1'b1; end
      OP_STI: begin ma = ptr_q; mw = 1'b1; end
      OP_STR: begin ma = regs_q[sr1] + sext(ir, 6); mw = 1'b1; end
      OP_TRAP: begin rv = pc1; rw = 1'b1; ri = 3'd7; pc_n = ptr_q; end
      default: un = 1'b1;
    endcase
    // store address wraps at the memory size
    ma = ma & 16'((32'd1 << AddrBits) - 32'd1);
    res_d = '0;
    res_d.pc_out = pc_q;
    res_d.cond_codes = cc_q;
    case (item_q.req_type)
      REQ_SET_PC: res_d.pc_out = ir;
      REQ_EXECUTE: begin
        res_d.pc_out = pc_n;
        res_d.reg_written = rw;
        res_d.reg_index = ri;
        res_d.reg_value = rv;
        res_d.mem_written = mw;
        res_d.mem_addr = ma;
        res_d.mem_data = mw ? regs_q[dr] : 16'd0;
        res_d.cond_codes = setcc ? cc_of(rv) : cc_q;
        res_d.unimplemented = un;
      end
      default: ;
    endcase
  end

  // memory write port: load requests and stores
  always_comb begin
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
    if (cmd_i.finish) begin
      if (item_q.req_type == REQ_MEM_WRITE) begin
        mem_we = 1'b1; mem_wa = item_q.addr[AddrBits-1:0]; mem_wd = ir;
      end else if (res_d.mem_written) begin
        mem_we = 1'b1; mem_wa = res_d.mem_addr[AddrBits-1:0]; mem_wd = res_d.mem_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      cc_q <= '0;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
    end else if (cmd_i.finish) begin
      pc_q <= res_d.pc_out;
      cc_q <= res_d.cond_codes;
      if (res_d.reg_written) regs_q[res_d.reg_index] <= res_d.reg_value;
    end
  end

  assign out_item_o = res_q;

  `ASSERT_NEVER(a_rd_exclusive, clk_i, rst_ni, cmd_i.rd1 && cmd_i.rd2, "two reads at once")
  `ASSERT_IMPL(a_rd2_follows, clk_i, rst_ni, cmd_i.rd2 |-> $past(cmd_i.rd1), "indirect read without first")
  `ASSERT_IMPL(a_cc_onehot, clk_i, rst_ni, cmd_i.finish |=> $onehot0(cc_q), "bad condition codes")
endmodule

/* tb/sv/tb_lc3_instruction_execute_unit.sv */
// testbench for the lc3 execute unit: predicted results checked against every transaction
`timescale 1ns / 1ps
module tb_lc3_instruction_execute_unit;
  import lc3_pkg::*;

  // architectural shadow of the core plus the queue of results still owed
  class exec_scoreboard;
    logic [15:0] regs [8];
    logic [15:0] pc;
    logic [2:0]  cc;
    logic [15:0] mem [65536];
    bit          written [65536];
    out_item_t   pending_results [$];
    int          errs;
    int          checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      cc = '0;
      errs = 0;
      checked = 0;
    endfunction

    static function logic [15:0] sx(logic [15:0] v, int bits);
      return 16'($signed(v << (16 - bits)) >>> (16 - bits));
    endfunction

    function logic [2:0] cc_from(logic [15:0] v);
      if (v[15]) return CcN;
      if (v == 16'd0) return CcZ;
      return CcP;
    endfunction

    task report_mismatch(string msg);
      errs++;
      $display("MISMATCH: %s", msg);
    endtask

    // apply one accepted request to the shadow state and queue its result
    function void note_input(in_item_t it);
      out_item_t   e;
      logic [15:0] ir, npc, b, ea;
      logic [2:0]  dr, sr1;
      logic        setcc;
      e = '0;
      setcc = 1'b0;
      ea = '0;
      case (req_type_e'(it.req_type))
        REQ_MEM_WRITE: begin
          mem[it.addr] = it.word;
          written[it.addr] = 1'b1;
        end
        REQ_SET_PC: pc = it.word;
        REQ_EXECUTE: begin
          ir = it.word;
          dr = ir[11:9];
          sr1 = ir[8:6];
          npc = pc + 16'd1;
          case (opcode_e'(ir[15:12]))
            OP_ADD, OP_AND: begin
              b = ir[5] ? sx(ir, 5) : regs[ir[2:0]];
              e.reg_value = (ir[15:12] == OP_ADD) ? regs[sr1] + b : regs[sr1] & b;
              e.reg_written = 1'b1;
              e.reg_index = dr;
              setcc = 1'b1;
            end
            OP_NOT: begin
              e.reg_value = ~regs[sr1];
              e.reg_written = 1'b1;
              e.reg_index = dr;
              setcc = 1'b1;
            end
            OP_BR: if ((dr & cc) != 3'd0) npc = npc + sx(ir, 9);
            OP_JMP: npc = regs[sr1];
            OP_JSR: begin
              e.reg_value = npc;
              npc = ir[11] ? npc + sx(ir, 11) : regs[sr1];
              e.reg_written = 1'b1;
              e.reg_index = 3'd7;
            end
            OP_LD, OP_LDI, OP_LEA: begin
              ea = npc + sx(ir, 9);
              case (opcode_e'(ir[15:12]))
                OP_LD:   e.reg_value = mem[ea];
                OP_LDI:  e.reg_value = mem[mem[ea]];
                default: e.reg_value = ea;
              endcase
              e.reg_written = 1'b1;
              e.reg_index = dr;
              setcc = 1'b1;
            end
            OP_LDR: begin
              ea = regs[sr1] + sx(ir, 6);
              e.reg_value = mem[ea];
              e.reg_written = 1'b1;
              e.reg_index = dr;
              setcc = 1'b1;
            end
            OP_ST: begin
              ea = npc + sx(ir, 9);
              e.mem_written = 1'b1;
            end
            OP_STI: begin
              ea = npc + sx(ir, 9);
              ea = mem[ea];
              e.mem_written = 1'b1;
            end
            OP_STR: begin
              ea = regs[sr1] + sx(ir, 6);
              e.mem_written = 1'b1;
            end
            OP_TRAP: begin
              e.reg_value = npc;
              e.reg_written = 1'b1;
              e.reg_index = 3'd7;
              npc = mem[{8'd0, ir[7:0]}];
            end
            default: e.unimplemented = 1'b1;
          endcase
          if (e.mem_written) begin
            e.mem_addr = ea;
            e.mem_data = regs[dr];
            mem[ea] = regs[dr];
            written[ea] = 1'b1;
          end
          if (e.reg_written) regs[e.reg_index] = e.reg_value;
          if (setcc) cc = cc_from(e.reg_value);
          pc = npc;
        end
        default: ;
      endcase
      e.pc_out = pc;
      e.cond_codes = cc;
      pending_results.push_back(e);
    endfunction

    // compare one result with the oldest prediction
    task check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      e = pending_results.pop_front();
      if (got.pc_out !== e.pc_out)
        report_mismatch($sformatf("pc_out %h exp %h", got.pc_out, e.pc_out));
      if (got.reg_written !== e.reg_written)
        report_mismatch($sformatf("reg_written %b exp %b", got.reg_written, e.reg_written));
      if (got.reg_index !== e.reg_index)
        report_mismatch($sformatf("reg_index %d exp %d", got.reg_index, e.reg_index));
      if (got.reg_value !== e.reg_value)
        report_mismatch($sformatf("reg_value %h exp %h", got.reg_value, e.reg_value));
      if (got.mem_written !== e.mem_written)
        report_mismatch($sformatf("mem_written %b exp %b", got.mem_written, e.mem_written));
      if (got.mem_addr !== e.mem_addr)
        report_mismatch($sformatf("mem_addr %h exp %h", got.mem_addr, e.mem_addr));
      if (got.mem_data !== e.mem_data)
        report_mismatch($sformatf("mem_data %h exp %h", got.mem_data, e.mem_data));
      if (got.cond_codes !== e.cond_codes)
        report_mismatch($sformatf("cond_codes %b exp %b", got.cond_codes, e.cond_codes));
      if (got.unimplemented !== e.unimplemented)
        report_mismatch($sformatf("unimplemented %b exp %b", got.unimplemented,
                                  e.unimplemented));
    endtask
  endclass

  localparam int IdleLimit = 4000;   // cycles with no transaction before giving up
  localparam int LongHold  = 400;    // receiver hold-off that backs up the core
  localparam int NumItems  = 1550;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  out_item_t out_data_o;

  exec_scoreboard sb = new();
  int  sent = 0;
  bit  quiet = 1'b0;   // phases with no idling on either side
  int  idle_cycles = 0;

  lc3_instruction_execute_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // offer one request and hold it until the core takes it
  task automatic send(logic [1:0] kind, logic [15:0] a, logic [15:0] w);
    int     gap;
    in_item_t it;
    gap = quiet ? 0 : $urandom_range(0, 15);
    it.req_type = kind;
    it.addr = a;
    it.word = w;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    sent++;
    if (sent % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
  endtask

  // make sure a memory word is defined before anything reads it
  task automatic ensure_written(logic [15:0] a);
    if (!sb.written[a]) send(REQ_MEM_WRITE, a, 16'($urandom));
  endtask

  // execute an instruction, first filling every word it will read
  task automatic exec(logic [15:0] ir);
    logic [15:0] npc, ea;
    npc = sb.pc + 16'd1;
    case (opcode_e'(ir[15:12]))
      OP_LD, OP_STI: ensure_written(npc + exec_scoreboard::sx(ir, 9));
      OP_LDI: begin
        ea = npc + exec_scoreboard::sx(ir, 9);
        ensure_written(ea);
        ensure_written(sb.mem[ea]);
      end
      OP_LDR: ensure_written(sb.regs[ir[8:6]] + exec_scoreboard::sx(ir, 6));
      OP_TRAP: ensure_written({8'd0, ir[7:0]});
      default: ;
    endcase
    send(REQ_EXECUTE, 16'($urandom), ir);
  endtask

  // sender: directed corner cases, then random traffic
  initial begin
    int r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(REQ_MEM_WRITE, 16'hFFFF, 16'hFFFF);
    send(REQ_MEM_WRITE, 16'h0000, 16'h0000);
    exec({OP_BR, 3'b111, 9'h0FF});               // nothing set yet, not taken
    send(REQ_SET_PC, 16'h0000, 16'hFFFE);
    exec({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10});     // r1 = -16
    exec({OP_ADD, 3'd2, 3'd1, 1'b1, 5'h0F});     // r2 = -1
    exec({OP_ADD, 3'd3, 3'd1, 1'b0, 2'b00, 3'd2});
    exec({OP_AND, 3'd4, 3'd2, 1'b1, 5'h10});     // and with sign-extended imm
    exec({OP_AND, 3'd5, 3'd0, 1'b0, 2'b00, 3'd2}); // zero result
    exec({OP_NOT, 3'd6, 3'd0, 6'h3F});
    exec({OP_BR, 3'b000, 9'h100});               // empty nzp never branches
    exec({OP_BR, 3'b111, 9'h100});
    exec({OP_LEA, 3'd0, 9'h1FF});
    exec({OP_LD, 3'd1, 9'h0FF});
    exec({OP_LDI, 3'd2, 9'h100});
    exec({OP_LDR, 3'd3, 3'd6, 6'h20});
    exec({OP_ST, 3'd6, 9'h1FF});
    exec({OP_STI, 3'd1, 9'h000});
    exec({OP_STR, 3'd2, 3'd7, 6'h1F});
    exec({OP_JSR, 1'b1, 11'h400});
    exec({OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00});    // jsrr through r7 uses the old r7
    exec({OP_JMP, 3'd0, 3'd2, 6'h00});
    exec({OP_TRAP, 4'h0, 8'hFF});
    exec({OP_RTI, 12'hFFF});
    exec({OP_RES, 12'h000});
    send(REQ_NONE, 16'hFFFF, 16'hFFFF);
    while (sent < NumItems) begin
      r = $urandom_range(0, 99);
      if (r < 10) send(REQ_MEM_WRITE, 16'($urandom), 16'($urandom));
      else if (r < 15) send(REQ_SET_PC, 16'($urandom), 16'($urandom));
      else if (r < 18) send(REQ_NONE, 16'($urandom), 16'($urandom));
      else exec(16'($urandom));
    end
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the core up
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && sb.checked == 300) begin
        held = 1'b1;
        gap = LongHold;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule
